// ===== rtl/fct_pkg.sv =====
// Shared constants and types for the frustum culling test block.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

  // Parameter defaults for the top level.
  localparam int NumPlanesDef = 6;
  localparam int CoordWDef    = 16;

  // Plane register layout: a, b, c are Q1.14 and d is Q15.0 (integer coordinate units), 16 bits each.
  localparam int CoefW     = 16;
  localparam int CfgDataW  = 64;
  localparam int CfgIdxW   = 3;
  localparam int CoefAPos  = 48;
  localparam int CoefBPos  = 32;
  localparam int CoefCPos  = 16;
  localparam int CoefDPos  = 0;

  // Scaling of d and the radius to the units of the plane products.
  localparam int NormShift = 14;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_POINT  = 2'd0,
    REQ_SPHERE = 2'd1,
    REQ_BOX    = 2'd2,
    REQ_RSVD   = 2'd3
  } req_kind_e;

  // Pipeline control handed to every plane evaluator.
  typedef struct packed {
    logic advance;
    logic is_box;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fct_if.sv =====
// Handshake channels of the frustum culling test: request and result.
`timescale 1ns / 1ps
`default_nettype none

interface fct_req_if #(
  parameter int COORD_WIDTH = fct_pkg::CoordWDef
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [COORD_WIDTH-1:0] x_or_min_x;
  logic signed [COORD_WIDTH-1:0] y_or_min_y;
  logic signed [COORD_WIDTH-1:0] z_or_min_z;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  logic signed [COORD_WIDTH-1:0] max_z;
  logic [COORD_WIDTH-2:0]        radius;

  modport source (
    output valid, req_type, x_or_min_x, y_or_min_y, z_or_min_z,
    output max_x, max_y, max_z, radius,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_or_min_x, y_or_min_y, z_or_min_z,
    input  max_x, max_y, max_z, radius,
    output ready
  );
endinterface

interface fct_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/fct_plane_regs.sv =====
// Clip plane configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_regs #(
  parameter int NUM_PLANES = fct_pkg::NumPlanesDef
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_we_i,
  input  wire logic [fct_pkg::CfgIdxW-1:0]              cfg_idx_i,
  input  wire logic [fct_pkg::CfgDataW-1:0]             cfg_data_i,
  output logic [NUM_PLANES-1:0][fct_pkg::CfgDataW-1:0]  planes_o
);

  logic [NUM_PLANES-1:0][fct_pkg::CfgDataW-1:0] planes_q;

  // One register per plane; writes to other indexes are dropped.
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        planes_q[i] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == fct_pkg::CfgIdxW'(i))) begin
        planes_q[i] <= cfg_data_i;
      end
    end
  end

  assign planes_o = planes_q;

endmodule

`default_nettype wire

// ===== rtl/fct_plane_eval.sv =====
// Three-stage evaluation of one clip plane against the current object.
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_eval #(
  parameter int COORD_WIDTH = fct_pkg::CoordWDef
) (
  input  wire logic                              clk_i,
  input  wire fct_pkg::pipe_ctl_t                ctl_i,
  input  wire logic [fct_pkg::CfgDataW-1:0]      plane_i,
  input  wire logic signed [COORD_WIDTH-1:0]     min_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     min_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     min_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]     max_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     max_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     max_z_i,
  input  wire logic [COORD_WIDTH-2:0]            radius_i,
  output logic                                   fail_o
);

  localparam int ProdW = fct_pkg::CoefW + COORD_WIDTH;
  localparam int OffsW = fct_pkg::CoefW + fct_pkg::NormShift;
  // The widest single term, plus room for the sum of five terms.
  localparam int TermW = (ProdW > OffsW) ? ProdW : OffsW;
  localparam int SumW  = TermW + 3;

  logic signed [fct_pkg::CoefW-1:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [COORD_WIDTH-1:0]    sel_x, sel_y, sel_z;

  logic signed [ProdW-1:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [ProdW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [SumW-1:0]  bias_d, bias_q;
  logic signed [SumW-1:0]  sum_xy_d, sum_xy_q, sum_zb_d, sum_zb_q;
  logic signed [SumW-1:0]  total;
  logic                    fail_d, fail_q;

  assign coef_a = plane_i[fct_pkg::CoefAPos +: fct_pkg::CoefW];
  assign coef_b = plane_i[fct_pkg::CoefBPos +: fct_pkg::CoefW];
  assign coef_c = plane_i[fct_pkg::CoefCPos +: fct_pkg::CoefW];
  assign coef_d = plane_i[fct_pkg::CoefDPos +: fct_pkg::CoefW];

  // Stage 1: for a box take the max corner on axes with a positive normal,
  // then form the three products and the scaled offset plus radius.
  assign sel_x = (ctl_i.is_box && (coef_a > 16'sd0)) ? max_x_i : min_x_i;
  assign sel_y = (ctl_i.is_box && (coef_b > 16'sd0)) ? max_y_i : min_y_i;
  assign sel_z = (ctl_i.is_box && (coef_c > 16'sd0)) ? max_z_i : min_z_i;

  assign prod_x_d = ProdW'(coef_a) * ProdW'(sel_x);
  assign prod_y_d = ProdW'(coef_b) * ProdW'(sel_y);
  assign prod_z_d = ProdW'(coef_c) * ProdW'(sel_z);
  assign bias_d   = $signed(SumW'(coef_d) <<< fct_pkg::NormShift)
                  + $signed(SumW'(radius_i) << fct_pkg::NormShift);

  // Stage 2: two partial sums.
  assign sum_xy_d = SumW'(prod_x_q) + SumW'(prod_y_q);
  assign sum_zb_d = SumW'(prod_z_q) + bias_q;

  // Stage 3: final sum; a negative value fails the plane.
  assign total  = sum_xy_q + sum_zb_q;
  assign fail_d = total[SumW-1];

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      bias_q   <= bias_d;
      sum_xy_q <= sum_xy_d;
      sum_zb_q <= sum_zb_d;
      fail_q   <= fail_d;
    end
  end

  assign fail_o = fail_q;

endmodule

`default_nettype wire

// ===== rtl/fct_result.sv =====
// Combines the plane verdicts and holds result words in an output register
// backed by a skid register.
`timescale 1ns / 1ps
`default_nettype none

module fct_result #(
  parameter int NUM_PLANES = fct_pkg::NumPlanesDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic                   rsvd_i,
  input  wire logic [NUM_PLANES-1:0]  fail_i,
  output logic                        advance_o,
  fct_res_if.source                   res_o
);

  logic push;
  logic push_inside;
  logic out_v_q, out_v_d;
  logic out_q, out_d;
  logic skid_v_q, skid_v_d;
  logic skid_q, skid_d;

  // The pipeline moves whenever the skid register is empty.
  assign advance_o   = !skid_v_q;
  assign push        = advance_o && valid_i;
  assign push_inside = !rsvd_i && !(|fail_i);

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      // Drain the skid word once the output is taken.
      if (res_o.ready) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (!out_v_q || res_o.ready) begin
      out_v_d = push;
      out_d   = push_inside;
    end else if (push) begin
      skid_v_d = 1'b1;
      skid_d   = push_inside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid      = out_v_q;
  assign res_o.inside_res = out_q;

endmodule

`default_nettype wire

// ===== rtl/frustum_cull_test.sv =====
// Top level of the frustum culling test: input stage, plane pipeline, result.
//
//   Channel   Dir  Modport  Word
//   req_i     in   sink     req_type, box min or center, box max, radius
//   res_o     out  source   inside_res
//   cfg_*     in   -        cfg_we_i, cfg_idx_i, cfg_data_i (plane write)
//
// One word is accepted per cycle while req_i.ready is high; a result word passes the
// input register, products, partial sums, final sum and output register in turn.
// The per-plane multiply and add tree forms the products, sums and final sum.
// Reset clears all planes to zero and empties the pipeline.
// When the output stalls, the last word lands in a skid register and
// req_i.ready drops until that register drains; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test #(
  parameter int NUM_PLANES  = fct_pkg::NumPlanesDef,
  parameter int COORD_WIDTH = fct_pkg::CoordWDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fct_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [fct_pkg::CfgDataW-1:0]  cfg_data_i,
  fct_req_if.sink                            req_i,
  fct_res_if.source                          res_o
);

  logic [NUM_PLANES-1:0][fct_pkg::CfgDataW-1:0] planes;
  logic [NUM_PLANES-1:0]                        fail;
  logic                                         advance;
  fct_pkg::pipe_ctl_t                           ctl;

  fct_pkg::req_kind_e            kind_q;
  logic signed [COORD_WIDTH-1:0] min_x_q, min_y_q, min_z_q;
  logic signed [COORD_WIDTH-1:0] max_x_q, max_y_q, max_z_q;
  logic [COORD_WIDTH-2:0]        radius_q;
  logic [COORD_WIDTH-2:0]        radius_eff;

  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic s1_rsvd_q, s2_rsvd_q, s3_rsvd_q;

  fct_plane_regs #(
    .NUM_PLANES (NUM_PLANES)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .planes_o   (planes)
  );

  assign req_i.ready = advance;

  // Input stage register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q   <= fct_pkg::req_kind_e'(req_i.req_type);
      min_x_q  <= req_i.x_or_min_x;
      min_y_q  <= req_i.y_or_min_y;
      min_z_q  <= req_i.z_or_min_z;
      max_x_q  <= req_i.max_x;
      max_y_q  <= req_i.max_y;
      max_z_q  <= req_i.max_z;
      radius_q <= req_i.radius;
    end
  end

  // Valid bits and the reserved-kind flag travel alongside the planes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q    <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s1_rsvd_q <= 1'b0;
      s2_rsvd_q <= 1'b0;
      s3_rsvd_q <= 1'b0;
    end else if (advance) begin
      s0_v_q    <= req_i.valid;
      s1_v_q    <= s0_v_q;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s1_rsvd_q <= (kind_q == fct_pkg::REQ_RSVD);
      s2_rsvd_q <= s1_rsvd_q;
      s3_rsvd_q <= s2_rsvd_q;
    end
  end

  // Only a sphere widens the pass margin by its radius.
  assign radius_eff  = (kind_q == fct_pkg::REQ_SPHERE) ? radius_q : '0;
  assign ctl.advance = advance;
  assign ctl.is_box  = (kind_q == fct_pkg::REQ_BOX);

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_eval
    fct_plane_eval #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_eval (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .plane_i  (planes[i]),
      .min_x_i  (min_x_q),
      .min_y_i  (min_y_q),
      .min_z_i  (min_z_q),
      .max_x_i  (max_x_q),
      .max_y_i  (max_y_q),
      .max_z_i  (max_z_q),
      .radius_i (radius_eff),
      .fail_o   (fail[i])
    );
  end

  fct_result #(
    .NUM_PLANES (NUM_PLANES)
  ) u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s3_v_q),
    .rsvd_i    (s3_rsvd_q),
    .fail_i    (fail),
    .advance_o (advance),
    .res_o     (res_o)
  );

`ifndef SYNTHESIS
  // The pipeline only holds while a result word is waiting at the output.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> res_o.valid)
    else $error("pipeline stalled with no result word at the output");

  // A finished item moving out of the last stage always shows at the output.
  a_last_stage_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s3_v_q) |=> res_o.valid)
    else $error("finished item did not reach the output");

  // The skid register fills only when the output word was refused.
  a_skid_on_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance ##1 !advance) |-> $past(res_o.valid && !res_o.ready))
    else $error("skid register filled without output backpressure");
`endif

endmodule

`default_nettype wire
